// ----- rtl/core/ethip_pkg.sv -----
// Shared types, codes and header offsets for the Ethernet/IPv4 header parser.
package ethip_pkg;

	// Default limit on counted bytes per frame
	localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;

	// EtherType and IP protocol numbers
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [3:0]  IHL_MIN    = 4'd5;

	// Byte offsets within the frame; OFS_TCP_FLAGS is relative to the transport header
	localparam int unsigned OFS_ETYPE_HI   = 12;
	localparam int unsigned OFS_ETYPE_LO   = 13;
	localparam int unsigned OFS_IP         = 14;
	localparam int unsigned OFS_TOTLEN_HI  = 16;
	localparam int unsigned OFS_TOTLEN_LO  = 17;
	localparam int unsigned OFS_ARP_OP_HI  = 20;
	localparam int unsigned OFS_ARP_OP_LO  = 21;
	localparam int unsigned OFS_TTL        = 22;
	localparam int unsigned OFS_PROTO      = 23;
	localparam int unsigned OFS_ADDR_FIRST = 26;
	localparam int unsigned OFS_ADDR_LAST  = 33;
	localparam int unsigned OFS_TCP_FLAGS  = 13;

	// Minimum frame lengths and transport header lengths
	localparam int unsigned NEED_ETH    = 14;
	localparam int unsigned NEED_ARP    = 42;
	localparam int unsigned NEED_IP_MIN = 34;
	localparam int unsigned TCP_HDR     = 20;
	localparam int unsigned SHORT_HDR   = 8;

	// Result codes
	localparam logic [1:0] FK_UNKNOWN = 2'd0;
	localparam logic [1:0] FK_IPV4    = 2'd1;
	localparam logic [1:0] FK_ARP     = 2'd2;
	localparam logic [1:0] TK_NONE    = 2'd0;
	localparam logic [1:0] TK_TCP     = 2'd1;
	localparam logic [1:0] TK_UDP     = 2'd2;
	localparam logic [1:0] TK_ICMP    = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} frame_word_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [1:0]  transport_kind;
		logic [5:0]  ip_header_bytes;
		logic [7:0]  ip_ttl;
		logic        ip_checksum_ok;
		logic        tcp_checksum_ok;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [7:0]  tcp_flag_bits;
		logic [15:0] type_or_opcode;
		logic [11:0] frame_bytes;
		logic        truncated;
	} summary_word_t;

	// Per-frame state captured at the last byte
	typedef struct packed {
		logic [15:0] byte_count;
		logic [15:0] ether_kind;
		logic [3:0]  header_words;
		logic [7:0]  protocol_number;
		logic [15:0] seg_length;
		logic [15:0] header_sum;
		logic [15:0] segment_sum;
		logic [7:0]  pending_high_byte;
		logic [7:0]  ttl_seen;
		logic [31:0] ports_seen;
		logic [7:0]  flags_seen;
		logic [15:0] code_seen;
	} snap_t;

	// Ones'-complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// ----- rtl/core/ethip_stream_if.sv -----
// Valid/ready channel interfaces for frame bytes and frame summaries.
interface ethip_frame_if import ethip_pkg::*; ();
	logic        valid;
	logic        ready;
	frame_word_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ethip_summary_if import ethip_pkg::*; ();
	logic          valid;
	logic          ready;
	summary_word_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/core/ethip_byte_parser.sv -----
// Input register, per-byte header state update and end-of-frame snapshot.
module ethip_byte_parser import ethip_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ethip_frame_if.sink   frame,
	output snap_t         snap,
	output logic          snap_valid,
	input  logic          snap_take
);

	localparam int unsigned OFS_W = $clog2(MAX_FRAME_BYTES + 1);

	// Input stage
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s1;
	logic       go;

	// Frame state
	logic [OFS_W-1:0] offset_q, offset_d;
	logic [15:0] ether_kind_q, ether_kind_d;
	logic [3:0]  header_words_q, header_words_d;
	logic [7:0]  protocol_q, protocol_d;
	logic [15:0] total_length_q, total_length_d;
	logic [15:0] header_sum_q, header_sum_d;
	logic [15:0] segment_sum_q, segment_sum_d;
	logic [7:0]  pending_q, pending_d;
	logic [7:0]  ttl_q, ttl_d;
	logic [31:0] ports_q, ports_d;
	logic [7:0]  flags_q, flags_d;
	logic [15:0] code_q, code_d;

	// Values derived from settled header fields, held in registers
	logic [6:0]  tstart_q;
	logic [15:0] seg_len_q;

	snap_t snap_q, snap_d;
	logic  snap_valid_q;

	logic             in_window;
	logic             is_ip;
	logic             is_arp;
	logic [15:0]      hdr_word;
	logic [OFS_W-1:0] rel_ofs;
	logic             in_hdr;
	logic             in_l4;
	logic             in_seg;

	// A last byte waits for a free snapshot slot; others always advance
	assign go          = valid_s1 && (!last_s1 || !snap_valid_q || snap_take);
	assign frame.ready = !valid_s1 || go;
	assign snap        = snap_q;
	assign snap_valid  = snap_valid_q;

	// Compute next frame state for the byte in the input stage
	always_comb begin
		offset_d       = offset_q;
		ether_kind_d   = ether_kind_q;
		header_words_d = header_words_q;
		protocol_d     = protocol_q;
		total_length_d = total_length_q;
		header_sum_d   = header_sum_q;
		segment_sum_d  = segment_sum_q;
		pending_d      = pending_q;
		ttl_d          = ttl_q;
		ports_d        = ports_q;
		flags_d        = flags_q;
		code_d         = code_q;

		in_window = offset_q < OFS_W'(MAX_FRAME_BYTES);
		is_ip     = ether_kind_q == ETYPE_IPV4;
		is_arp    = ether_kind_q == ETYPE_ARP;
		hdr_word  = offset_q[0] ? {8'h00, byte_s1} : {byte_s1, 8'h00};
		rel_ofs   = offset_q - OFS_W'(tstart_q);
		if (offset_q == OFS_W'(OFS_IP)) begin
			in_hdr = byte_s1[3:0] != 4'd0;
		end else begin
			in_hdr = offset_q < (OFS_W'(OFS_IP) + OFS_W'({header_words_q, 2'b00}));
		end
		in_l4  = (header_words_q >= IHL_MIN) && (offset_q >= OFS_W'(tstart_q));
		in_seg = 16'(rel_ofs) < seg_len_q;

		if (in_window) begin
			offset_d = offset_q + OFS_W'(1);
			if (offset_q == OFS_W'(OFS_ETYPE_HI)) begin
				ether_kind_d = {byte_s1, 8'h00};
			end
			if (offset_q == OFS_W'(OFS_ETYPE_LO)) begin
				ether_kind_d[7:0] = byte_s1;
			end

			if (is_arp) begin
				// Capture the ARP opcode
				if (offset_q == OFS_W'(OFS_ARP_OP_HI)) begin
					code_d[15:8] = byte_s1;
				end
				if (offset_q == OFS_W'(OFS_ARP_OP_LO)) begin
					code_d[7:0] = byte_s1;
				end
			end else if (is_ip && offset_q >= OFS_W'(OFS_IP)) begin
				if (offset_q == OFS_W'(OFS_IP)) begin
					header_words_d = byte_s1[3:0];
				end
				if (in_hdr) begin
					header_sum_d = oc_add(header_sum_q, hdr_word);
				end
				if (offset_q == OFS_W'(OFS_TOTLEN_HI)) begin
					total_length_d = {byte_s1, 8'h00};
				end
				if (offset_q == OFS_W'(OFS_TOTLEN_LO)) begin
					total_length_d[7:0] = byte_s1;
				end
				if (offset_q == OFS_W'(OFS_TTL)) begin
					ttl_d = byte_s1;
				end
				if (offset_q == OFS_W'(OFS_PROTO)) begin
					protocol_d = byte_s1;
				end
				// Source and destination addresses go into the pseudo-header sum
				if (offset_q >= OFS_W'(OFS_ADDR_FIRST) && offset_q <= OFS_W'(OFS_ADDR_LAST)) begin
					segment_sum_d = oc_add(segment_sum_q, hdr_word);
				end
				// Transport header and segment
				if (in_l4) begin
					if (rel_ofs < OFS_W'(4)) begin
						case (rel_ofs[1:0])
							2'd0: ports_d[31:24] = byte_s1;
							2'd1: ports_d[23:16] = byte_s1;
							2'd2: ports_d[15:8]  = byte_s1;
							default: ports_d[7:0] = byte_s1;
						endcase
					end
					if (rel_ofs == OFS_W'(0)) begin
						code_d = {8'h00, byte_s1};
					end
					if (rel_ofs == OFS_W'(OFS_TCP_FLAGS)) begin
						flags_d = byte_s1;
					end
					if (in_seg) begin
						if (!offset_q[0]) begin
							pending_d = byte_s1;
						end else begin
							segment_sum_d = oc_add(segment_sum_q, {pending_q, byte_s1});
							pending_d     = 8'h00;
						end
					end
				end
			end
		end

		snap_d.byte_count        = 16'(offset_d);
		snap_d.ether_kind        = ether_kind_d;
		snap_d.header_words      = header_words_d;
		snap_d.protocol_number   = protocol_d;
		snap_d.seg_length        = seg_len_q;
		snap_d.header_sum        = header_sum_d;
		snap_d.segment_sum       = segment_sum_d;
		snap_d.pending_high_byte = pending_d;
		snap_d.ttl_seen          = ttl_d;
		snap_d.ports_seen        = ports_d;
		snap_d.flags_seen        = flags_d;
		snap_d.code_seen         = code_d;
	end

	// Hold control and frame state; clear the frame after its last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			snap_valid_q   <= 1'b0;
			offset_q       <= '0;
			ether_kind_q   <= '0;
			header_words_q <= '0;
			protocol_q     <= '0;
			total_length_q <= '0;
			header_sum_q   <= '0;
			segment_sum_q  <= '0;
			pending_q      <= '0;
			ttl_q          <= '0;
			ports_q        <= '0;
			flags_q        <= '0;
			code_q         <= '0;
			tstart_q       <= '0;
			seg_len_q      <= '0;
		end else begin
			if (frame.valid && frame.ready) begin
				valid_s1 <= 1'b1;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end

			if (go && last_s1) begin
				snap_valid_q <= 1'b1;
			end else if (snap_take) begin
				snap_valid_q <= 1'b0;
			end

			tstart_q  <= 7'(OFS_IP) + {1'b0, header_words_q, 2'b00};
			seg_len_q <= total_length_q - {10'd0, header_words_q, 2'b00};

			if (go) begin
				if (last_s1) begin
					offset_q       <= '0;
					ether_kind_q   <= '0;
					header_words_q <= '0;
					protocol_q     <= '0;
					total_length_q <= '0;
					header_sum_q   <= '0;
					segment_sum_q  <= '0;
					pending_q      <= '0;
					ttl_q          <= '0;
					ports_q        <= '0;
					flags_q        <= '0;
					code_q         <= '0;
				end else begin
					offset_q       <= offset_d;
					ether_kind_q   <= ether_kind_d;
					header_words_q <= header_words_d;
					protocol_q     <= protocol_d;
					total_length_q <= total_length_d;
					header_sum_q   <= header_sum_d;
					segment_sum_q  <= segment_sum_d;
					pending_q      <= pending_d;
					ttl_q          <= ttl_d;
					ports_q        <= ports_d;
					flags_q        <= flags_d;
					code_q         <= code_d;
				end
			end
		end
	end

	// Load the input word and the end-of-frame snapshot
	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.payload.data_byte;
			last_s1 <= frame.payload.last_byte;
		end
		if (go && last_s1) begin
			snap_q <= snap_d;
		end
	end

endmodule

// ----- rtl/core/ethip_summary_build.sv -----
// Length checks, transport checksum fold and the summary output register.
module ethip_summary_build import ethip_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  snap_t           snap,
	input  logic            snap_valid,
	output logic            snap_take,
	ethip_summary_if.source summary
);

	logic          out_valid_q;
	summary_word_t out_q;
	summary_word_t res;

	logic        is_ip;
	logic        is_arp;
	logic        l4_ok;
	logic [6:0]  tstart;
	logic [6:0]  need;
	logic [17:0] tcp_sum;
	logic [16:0] fold1;
	logic [15:0] fold2;
	logic        tcp_ok;

	assign snap_take     = snap_valid && (!out_valid_q || summary.ready);
	assign summary.valid = out_valid_q;
	assign summary.payload = out_q;

	// Build the summary from the captured frame state
	always_comb begin
		is_ip  = snap.ether_kind == ETYPE_IPV4;
		is_arp = snap.ether_kind == ETYPE_ARP;
		l4_ok  = snap.header_words >= IHL_MIN;
		tstart = 7'(OFS_IP) + {1'b0, snap.header_words, 2'b00};

		// Bytes required before the headers count as complete
		if (is_ip) begin
			if (l4_ok) begin
				if (snap.protocol_number == PROTO_TCP) begin
					need = tstart + 7'(TCP_HDR);
				end else if (snap.protocol_number == PROTO_UDP ||
					snap.protocol_number == PROTO_ICMP) begin
					need = tstart + 7'(SHORT_HDR);
				end else begin
					need = tstart;
				end
			end else begin
				need = 7'(NEED_IP_MIN);
			end
		end else if (is_arp) begin
			need = 7'(NEED_ARP);
		end else begin
			need = 7'(NEED_ETH);
		end

		// Pseudo-header sum: protocol, segment length and a zero-padded odd byte
		tcp_sum = 18'(snap.segment_sum) + 18'(PROTO_TCP) + 18'(snap.seg_length) +
			(snap.seg_length[0] ? 18'({snap.pending_high_byte, 8'h00}) : 18'd0);
		fold1  = 17'(tcp_sum[15:0]) + 17'(tcp_sum[17:16]);
		fold2  = fold1[15:0] + 16'(fold1[16]);
		tcp_ok = (17'(snap.byte_count) >= (17'(tstart) + 17'(snap.seg_length))) &&
			(fold2 == 16'hFFFF);

		res = '0;
		res.frame_bytes = snap.byte_count[11:0];
		if (snap.byte_count < 16'(need)) begin
			res.truncated = 1'b1;
		end else if (is_ip) begin
			res.frame_kind      = FK_IPV4;
			res.ip_header_bytes = {snap.header_words, 2'b00};
			res.ip_ttl          = snap.ttl_seen;
			res.ip_checksum_ok  = snap.header_sum == 16'hFFFF;
			if (l4_ok) begin
				if (snap.protocol_number == PROTO_TCP) begin
					res.transport_kind  = TK_TCP;
					res.tcp_checksum_ok = tcp_ok;
					res.src_port        = snap.ports_seen[31:16];
					res.dst_port        = snap.ports_seen[15:0];
					res.tcp_flag_bits   = snap.flags_seen;
				end else if (snap.protocol_number == PROTO_UDP) begin
					res.transport_kind = TK_UDP;
					res.src_port       = snap.ports_seen[31:16];
					res.dst_port       = snap.ports_seen[15:0];
				end else if (snap.protocol_number == PROTO_ICMP) begin
					res.transport_kind = TK_ICMP;
					res.type_or_opcode = {8'h00, snap.code_seen[7:0]};
				end
			end
		end else if (is_arp) begin
			res.frame_kind     = FK_ARP;
			res.type_or_opcode = snap.code_seen;
		end
	end

	// Hold the summary until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_take) begin
			out_valid_q <= 1'b1;
		end else if (summary.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_take) begin
			out_q <= res;
		end
	end

endmodule

// ----- rtl/core/ethernet_ipv4_header_parser_unit.sv -----
// Top level of the Ethernet/IPv4 header parser: byte parser and summary stage.
//
// The frame channel carries one frame byte per word, starting at the
// destination MAC, with last_byte set on the final byte. The summary channel
// carries one word per frame: frame class, IPv4 header length, TTL, header and
// TCP checksum results, ports, TCP flags, ICMP type or ARP opcode, the byte
// count and a truncation mark.
// Throughput is one byte per cycle while no last byte waits for the snapshot
// register. A byte is held in the input register, updates the running header
// state and sums in the next cycle, and on the last byte that state is captured
// in a snapshot register, from which the summary register is loaded. Bytes past
// MAX_FRAME_BYTES are ignored and not counted.
// Reset clears all frame state and the channels' valid flags; no summary is
// pending afterwards. When the receiver stalls, the summary register holds its
// word and the snapshot register holds one more; bytes that are not last keep
// flowing, and a last byte waits in the input register until the snapshot
// register frees up, which drops frame.ready.
module ethernet_ipv4_header_parser_unit import ethip_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	ethip_frame_if.sink     frame,
	ethip_summary_if.source summary
);

	snap_t snap;
	logic  snap_valid;
	logic  snap_take;

	ethip_byte_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame      (frame),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_take  (snap_take)
	);

	ethip_summary_build u_summary (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap       (snap),
		.snap_valid (snap_valid),
		.snap_take  (snap_take),
		.summary    (summary)
	);

`ifndef SYNTHESIS
	// A snapshot that is not taken stays put
	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid && !snap_take |=> snap_valid && $stable(snap))
		else $error("snapshot lost or changed while waiting");

	// A taken snapshot shows up as a summary word
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		snap_take |=> summary.valid)
		else $error("summary missing after snapshot transfer");

	// Truncated frames report no class and no transport fields
	a_trunc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		summary.valid && summary.payload.truncated |->
		summary.payload.frame_kind == FK_UNKNOWN &&
		summary.payload.transport_kind == TK_NONE &&
		summary.payload.src_port == 16'd0)
		else $error("truncated summary carries parsed fields");

	// Transport fields only appear for IPv4
	a_l4_ipv4: assert property (@(posedge clk) disable iff (!arst_n)
		summary.valid && summary.payload.frame_kind != FK_IPV4 |->
		summary.payload.transport_kind == TK_NONE &&
		!summary.payload.tcp_checksum_ok)
		else $error("transport result on a non-IPv4 frame");
`endif

endmodule

// ----- tb/sv/ethip_summary_checker.sv -----
// Summary checker: predicts one summary word per frame from the accepted bytes and compares.
`timescale 1ns / 1ps

module ethip_summary_checker import ethip_pkg::*; (
	input  logic          clk,
	input  logic          frame_valid,
	input  logic          frame_ready,
	input  frame_word_t   frame_word,
	input  logic          summary_valid,
	input  logic          summary_ready,
	input  summary_word_t summary_word,
	output int            mismatch_count,
	output int            summaries_owed
);

	// Per-frame parse state, cleared at every last byte
	logic [11:0] byte_pos    = '0;
	logic [15:0] etype       = '0;
	logic [3:0]  ihl         = '0;
	logic [7:0]  proto       = '0;
	logic [15:0] tot_len     = '0;
	logic [15:0] hdr_sum     = '0;
	logic [15:0] seg_sum     = '0;
	logic [7:0]  held_byte   = '0;
	logic [7:0]  ttl_q       = '0;
	logic [31:0] port_pair   = '0;
	logic [7:0]  tcp_flags   = '0;
	logic [15:0] icmp_or_op  = '0;

	summary_word_t expected_summaries[$];
	summary_word_t oldest_summary;
	int            fail_tally = 0;
	int            owed_tally = 0;

	assign mismatch_count = fail_tally;
	assign summaries_owed = owed_tally;

	// Fold carries back into the low 16 bits (end-around carry)
	function automatic logic [15:0] ones_fold(input logic [31:0] s);
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		return s[15:0];
	endfunction

	// Advance the parse state by one frame byte
	task automatic absorb_frame_byte(input logic [7:0] b);
		int unsigned idx, hl, rel, r;
		logic [15:0] seglen;
		// drop bytes past the frame limit; they are not counted
		if (byte_pos >= MAX_FRAME_BYTES_DEF)
			return;
		idx = 32'(byte_pos);
		byte_pos = byte_pos + 12'd1;
		if (idx == OFS_ETYPE_HI) etype = {b, 8'h00};
		if (idx == OFS_ETYPE_LO) etype[7:0] = b;
		if (etype == ETYPE_ARP) begin
			if (idx == OFS_ARP_OP_HI) icmp_or_op = {b, 8'h00};
			if (idx == OFS_ARP_OP_LO) icmp_or_op[7:0] = b;
			return;
		end
		if (etype != ETYPE_IPV4 || idx < OFS_IP)
			return;
		if (idx == OFS_IP) ihl = b[3:0];
		hl = ihl * 4;
		rel = idx - OFS_IP;
		// header sum over IHL*4 bytes, even offsets are the high byte
		if (rel < hl)
			hdr_sum = ones_fold(32'(hdr_sum) + ((rel % 2) ? {24'd0, b} : {16'd0, b, 8'd0}));
		if (idx == OFS_TOTLEN_HI) tot_len = {b, 8'h00};
		if (idx == OFS_TOTLEN_LO) tot_len[7:0] = b;
		if (idx == OFS_TTL) ttl_q = b;
		if (idx == OFS_PROTO) proto = b;
		// source and destination addresses feed the pseudo-header
		if (idx >= OFS_ADDR_FIRST && idx <= OFS_ADDR_LAST)
			seg_sum = ones_fold(32'(seg_sum) + ((idx % 2) ? {24'd0, b} : {16'd0, b, 8'd0}));
		if (ihl >= IHL_MIN && idx >= OFS_IP + hl) begin
			r = idx - OFS_IP - hl;
			if (r < 4) port_pair[8 * (3 - r) +: 8] = b;
			if (r == 0) icmp_or_op = {8'd0, b};
			if (r == OFS_TCP_FLAGS) tcp_flags = b;
			seglen = tot_len - 16'(hl);
			// pair segment bytes into words; hold the high byte until its partner comes
			if (r < seglen) begin
				if ((r % 2) == 0) begin
					held_byte = b;
				end else begin
					seg_sum = ones_fold(32'(seg_sum) + {16'd0, held_byte, b});
					held_byte = '0;
				end
			end
		end
	endtask

	// Build the summary of the finished frame and clear the parse state
	function automatic summary_word_t summarize_frame();
		summary_word_t s;
		int unsigned n, hl, t, need;
		logic [15:0] len;
		logic [31:0] tsum;
		s = '0;
		n = 32'(byte_pos);
		hl = ihl * 4;
		t = 0;
		s.frame_bytes = byte_pos;
		if (etype == ETYPE_IPV4) begin
			need = NEED_IP_MIN;
			if (ihl >= IHL_MIN) begin
				t = OFS_IP + hl;
				need = t;
				if (proto == PROTO_TCP)
					need = t + TCP_HDR;
				else if (proto == PROTO_UDP || proto == PROTO_ICMP)
					need = t + SHORT_HDR;
			end
		end else if (etype == ETYPE_ARP) begin
			need = NEED_ARP;
		end else begin
			need = NEED_ETH;
		end
		if (n < NEED_ETH || n < need) begin
			s.truncated = 1'b1;
		end else if (etype == ETYPE_IPV4) begin
			s.frame_kind = FK_IPV4;
			s.ip_header_bytes = 6'(hl);
			s.ip_ttl = ttl_q;
			s.ip_checksum_ok = (hdr_sum == 16'hFFFF);
			if (ihl >= IHL_MIN) begin
				if (proto == PROTO_TCP) begin
					len = tot_len - 16'(hl);
					// pad an odd last segment byte with zero
					tsum = 32'(seg_sum) + 32'(proto) + 32'(len)
						+ (len[0] ? {16'd0, held_byte, 8'd0} : 32'd0);
					s.transport_kind = TK_TCP;
					s.tcp_checksum_ok = (n >= t + len) && (ones_fold(tsum) == 16'hFFFF);
					s.src_port = port_pair[31:16];
					s.dst_port = port_pair[15:0];
					s.tcp_flag_bits = tcp_flags;
				end else if (proto == PROTO_UDP) begin
					s.transport_kind = TK_UDP;
					s.src_port = port_pair[31:16];
					s.dst_port = port_pair[15:0];
				end else if (proto == PROTO_ICMP) begin
					s.transport_kind = TK_ICMP;
					s.type_or_opcode = {8'd0, icmp_or_op[7:0]};
				end
			end
		end else if (etype == ETYPE_ARP) begin
			s.frame_kind = FK_ARP;
			s.type_or_opcode = icmp_or_op;
		end
		byte_pos = '0; etype = '0; ihl = '0; proto = '0; tot_len = '0; hdr_sum = '0;
		seg_sum = '0; held_byte = '0; ttl_q = '0; port_pair = '0; tcp_flags = '0;
		icmp_or_op = '0;
		return s;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
		fail_tally++;
	endtask

	task automatic compare_summary(input summary_word_t got, input summary_word_t want);
		if (got.frame_kind !== want.frame_kind)
			report_mismatch("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
		if (got.transport_kind !== want.transport_kind)
			report_mismatch("transport_kind", 32'(got.transport_kind),
				32'(want.transport_kind));
		if (got.ip_header_bytes !== want.ip_header_bytes)
			report_mismatch("ip_header_bytes", 32'(got.ip_header_bytes),
				32'(want.ip_header_bytes));
		if (got.ip_ttl !== want.ip_ttl)
			report_mismatch("ip_ttl", 32'(got.ip_ttl), 32'(want.ip_ttl));
		if (got.ip_checksum_ok !== want.ip_checksum_ok)
			report_mismatch("ip_checksum_ok", 32'(got.ip_checksum_ok),
				32'(want.ip_checksum_ok));
		if (got.tcp_checksum_ok !== want.tcp_checksum_ok)
			report_mismatch("tcp_checksum_ok", 32'(got.tcp_checksum_ok),
				32'(want.tcp_checksum_ok));
		if (got.src_port !== want.src_port)
			report_mismatch("src_port", 32'(got.src_port), 32'(want.src_port));
		if (got.dst_port !== want.dst_port)
			report_mismatch("dst_port", 32'(got.dst_port), 32'(want.dst_port));
		if (got.tcp_flag_bits !== want.tcp_flag_bits)
			report_mismatch("tcp_flag_bits", 32'(got.tcp_flag_bits),
				32'(want.tcp_flag_bits));
		if (got.type_or_opcode !== want.type_or_opcode)
			report_mismatch("type_or_opcode", 32'(got.type_or_opcode),
				32'(want.type_or_opcode));
		if (got.frame_bytes !== want.frame_bytes)
			report_mismatch("frame_bytes", 32'(got.frame_bytes), 32'(want.frame_bytes));
		if (got.truncated !== want.truncated)
			report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
	endtask

	// Compare each accepted summary word first, then absorb the accepted frame word
	always @(posedge clk) begin
		if (summary_valid === 1'b1 && summary_ready === 1'b1) begin
			if (expected_summaries.size() == 0) begin
				report_mismatch("summary word with no frame pending",
					32'(summary_word.frame_bytes), 32'd0);
			end else begin
				oldest_summary = expected_summaries.pop_front();
				compare_summary(summary_word, oldest_summary);
			end
		end
		if (frame_valid === 1'b1 && frame_ready === 1'b1) begin
			absorb_frame_byte(frame_word.data_byte);
			if (frame_word.last_byte)
				expected_summaries.push_back(summarize_frame());
		end
		owed_tally = expected_summaries.size();
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the parser testbench: frame stimulus, summary back-pressure and the verdict.
`timescale 1ns / 1ps

module testbench;
	import ethip_pkg::*;

	localparam int HOLD_OFF_CYCLES   = 600;
	localparam int RANDOM_BYTES      = 800;
	localparam int RANDOM_FRAMES_MIN = 12;
	localparam int DRAIN_CYCLES      = 20;
	localparam int LIMIT_NS          = 1_000_000;
	localparam int IP_CSUM_OFS       = 24;
	localparam int TCP_CSUM_OFS      = 16;

	typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	logic clk;
	logic arst_n;

	ethip_frame_if   frame_ch();
	ethip_summary_if summary_ch();

	int          mismatch_count;
	int          summaries_owed;
	logic [7:0]  frame_q[$];
	int          burst_left;
	int          random_bytes;
	int          random_frames;
	bit          hold_off_req;
	rx_pattern_t rx_pattern;
	int          rx_left;
	int          rx_phase;

	ethernet_ipv4_header_parser_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.summary (summary_ch)
	);

	ethip_summary_checker summary_check (
		.clk            (clk),
		.frame_valid    (frame_ch.valid),
		.frame_ready    (frame_ch.ready),
		.frame_word     (frame_ch.payload),
		.summary_valid  (summary_ch.valid),
		.summary_ready  (summary_ch.ready),
		.summary_word   (summary_ch.payload),
		.mismatch_count (mismatch_count),
		.summaries_owed (summaries_owed)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ones'-complement sum of frame bytes, even relative offsets as the high byte
	function automatic logic [15:0] byte_sum(input int first, input int count,
			input logic [31:0] seed);
		logic [31:0] acc;
		acc = seed;
		for (int i = 0; i < count; i++)
			acc += (i % 2 == 0) ? {16'd0, frame_q[first + i], 8'd0} : {24'd0, frame_q[first + i]};
		while (acc[31:16] != 0)
			acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
		return acc[15:0];
	endfunction

	task automatic push_random(input int count);
		repeat (count) frame_q.push_back(8'($urandom));
	endtask

	// Frame with MAC addresses, a given EtherType and random payload up to len bytes
	task automatic build_plain(input logic [15:0] etype, input int len);
		frame_q.delete();
		push_random(12);
		frame_q.push_back(etype[15:8]);
		frame_q.push_back(etype[7:0]);
		if (len > 14) push_random(len - 14);
	endtask

	// Write the IPv4 header checksum and, for TCP, the segment checksum, good or broken
	task automatic seal_checksums(input bit ip_good, input bit tcp_good);
		int hl, t;
		logic [15:0] tot, len, ck;
		hl = frame_q[OFS_IP][3:0] * 4;
		if (hl < IHL_MIN * 4 || OFS_IP + hl > frame_q.size())
			return;
		frame_q[IP_CSUM_OFS] = '0;
		frame_q[IP_CSUM_OFS + 1] = '0;
		ck = ~byte_sum(OFS_IP, hl, 0);
		if (!ip_good) ck ^= 16'($urandom_range(1, 65535));
		frame_q[IP_CSUM_OFS] = ck[15:8];
		frame_q[IP_CSUM_OFS + 1] = ck[7:0];
		if (frame_q[OFS_PROTO] != PROTO_TCP)
			return;
		t = OFS_IP + hl;
		tot = {frame_q[OFS_TOTLEN_HI], frame_q[OFS_TOTLEN_LO]};
		len = tot - 16'(hl);
		if (t + TCP_CSUM_OFS + 2 > frame_q.size() || t + len > frame_q.size())
			return;
		frame_q[t + TCP_CSUM_OFS] = '0;
		frame_q[t + TCP_CSUM_OFS + 1] = '0;
		ck = ~byte_sum(t, len, 32'(byte_sum(OFS_ADDR_FIRST, 8, 32'(PROTO_TCP) + 32'(len))));
		if (!tcp_good) ck ^= 16'($urandom_range(1, 65535));
		frame_q[t + TCP_CSUM_OFS] = ck[15:8];
		frame_q[t + TCP_CSUM_OFS + 1] = ck[7:0];
	endtask

	// IPv4 frame: header (options past 20 bytes), segment, Ethernet padding
	task automatic build_ipv4(input logic [3:0] ihl, input logic [7:0] proto, input int seg_bytes,
			input int pad, input int len_skew, input bit ip_good, input bit tcp_good);
		int hl;
		logic [15:0] tot;
		hl = ihl * 4;
		build_plain(ETYPE_IPV4, 14);
		frame_q.push_back({($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'd4, ihl});
		push_random(1);
		tot = 16'(hl + seg_bytes + len_skew);
		frame_q.push_back(tot[15:8]);
		frame_q.push_back(tot[7:0]);
		push_random(5);
		frame_q.push_back(proto);
		push_random(10);
		if (hl > IHL_MIN * 4) push_random(hl - IHL_MIN * 4);
		push_random(seg_bytes);
		push_random(pad);
		seal_checksums(ip_good, tcp_good);
	endtask

	task automatic trim_frame(input int count);
		repeat (count) void'(frame_q.pop_back());
	endtask

	// Offer the frame word by word, in bursts with idle gaps between them
	task automatic send_frame();
		int gap;
		frame_word_t word;
		for (int i = 0; i < frame_q.size(); i++) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					frame_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 20);
			end
			word.data_byte = frame_q[i];
			word.last_byte = (i == frame_q.size() - 1);
			frame_ch.valid <= 1'b1;
			frame_ch.payload <= word;
			@(posedge clk);
			while (frame_ch.ready !== 1'b1) @(posedge clk);
			burst_left--;
		end
	endtask

	// Field extremes, every frame class and the corner cases of length and checksum
	task automatic run_directed();
		int t;
		t = OFS_IP + IHL_MIN * 4;
		// runts shorter than the Ethernet header, a bare header, all-zero and all-ones frames
		frame_q.delete(); push_random(1); send_frame();
		frame_q.delete(); push_random(13); send_frame();
		build_plain(16'h1234, 14); send_frame();
		frame_q.delete(); repeat (60) frame_q.push_back(8'h00); send_frame();
		frame_q.delete(); repeat (60) frame_q.push_back(8'hFF); send_frame();
		// EtherType whose high byte alone looks like IPv4
		build_plain(16'h0808, 30); send_frame();
		// ARP: opcode extremes, one byte short
		build_plain(ETYPE_ARP, 42);
		frame_q[OFS_ARP_OP_HI] = 8'h00; frame_q[OFS_ARP_OP_LO] = 8'h01; send_frame();
		build_plain(ETYPE_ARP, 60);
		frame_q[OFS_ARP_OP_HI] = 8'hFF; frame_q[OFS_ARP_OP_LO] = 8'hFF; send_frame();
		build_plain(ETYPE_ARP, 41); send_frame();
		// TCP with port and flag extremes, even and odd segment lengths, a bad segment checksum
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 0, 0, 1, 1);
		frame_q[t] = 8'hFF; frame_q[t + 1] = 8'hFF; frame_q[t + 2] = 8'h00; frame_q[t + 3] = 8'h00;
		frame_q[t + OFS_TCP_FLAGS] = 8'hFF;
		seal_checksums(1, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_TCP, 21, 3, 0, 1, 1);
		frame_q[t] = 8'h00; frame_q[t + 1] = 8'h00; frame_q[t + 2] = 8'hFF; frame_q[t + 3] = 8'hFF;
		frame_q[t + OFS_TCP_FLAGS] = 8'h00;
		seal_checksums(1, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_TCP, 24, 0, 0, 1, 0); send_frame();
		// segment runs past the frame end; total length below the header length; UDP, ICMP, other protocol
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 0, 10, 1, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 0, -30, 1, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_UDP, 8, 0, 0, 1, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_ICMP, 8, 0, 0, 1, 1);
		frame_q[t] = 8'hFF; seal_checksums(1, 1); send_frame();
		build_ipv4(IHL_MIN, 8'd50, 10, 0, 0, 1, 1); send_frame();
		// short and maximal header lengths
		build_ipv4(4'd0, PROTO_TCP, 0, 0, 0, 1, 1); send_frame();
		build_ipv4(4'd4, PROTO_UDP, 0, 6, 0, 1, 1); send_frame();
		build_ipv4(4'd15, PROTO_TCP, 20, 0, 0, 1, 1); send_frame();
		// TTL extremes, bad header checksum
		build_ipv4(IHL_MIN, PROTO_UDP, 8, 0, 0, 1, 1);
		frame_q[OFS_TTL] = 8'h00; seal_checksums(0, 1); send_frame();
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 0, 0, 1, 1);
		frame_q[OFS_TTL] = 8'hFF; seal_checksums(1, 1); send_frame();
		// truncated IPv4 header and truncated TCP header
		build_ipv4(IHL_MIN, PROTO_UDP, 8, 0, 0, 1, 1); trim_frame(9); send_frame();
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 0, 0, 1, 1); trim_frame(1); send_frame();
		// frame just past the byte limit
		build_ipv4(IHL_MIN, PROTO_TCP, 20, 1996, 0, 1, 1); send_frame();
	endtask

	// One random frame: mostly well-formed, some noise and broken frames
	task automatic make_random_frame();
		int pick;
		bit ip_good, tcp_good;
		logic [3:0] ihl;
		pick = $urandom_range(0, 99);
		ip_good = ($urandom_range(0, 9) != 0);
		tcp_good = ($urandom_range(0, 6) != 0);
		ihl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(6, 15)) : IHL_MIN;
		if (pick < 35) begin
			build_ipv4(ihl, PROTO_TCP, $urandom_range(20, 48),
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0, 0, ip_good, tcp_good);
		end else if (pick < 55) begin
			build_ipv4(ihl, PROTO_UDP, $urandom_range(8, 30), 0, 0, ip_good, 1);
		end else if (pick < 70) begin
			build_ipv4(ihl, PROTO_ICMP, $urandom_range(8, 30), 0, 0, ip_good, 1);
		end else if (pick < 75) begin
			build_ipv4(ihl, 8'($urandom), $urandom_range(0, 20), 0, 0, ip_good, tcp_good);
		end else if (pick < 85) begin
			build_plain(ETYPE_ARP, $urandom_range(42, 60));
		end else if (pick < 90) begin
			build_plain(16'($urandom), $urandom_range(14, 70));
		end else if (pick < 95) begin
			frame_q.delete();
			push_random($urandom_range(1, 80));
		end else begin
			// broken: skewed total length, short IHL, or cut short
			case ($urandom_range(0, 2))
				0: build_ipv4(IHL_MIN, PROTO_TCP, $urandom_range(20, 40), $urandom_range(0, 8),
					int'($urandom_range(0, 80)) - 40, ip_good, tcp_good);
				1: build_ipv4(4'($urandom_range(0, 4)), 8'($urandom_range(0, 20)),
					$urandom_range(0, 30), 0, 0, ip_good, tcp_good);
				default: begin
					build_ipv4(ihl, ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP,
						$urandom_range(8, 30), 0, 0, ip_good, tcp_good);
					trim_frame($urandom_range(1, frame_q.size() - 1));
				end
			endcase
		end
	endtask

	// Summary back-pressure: changing stall patterns, plus long hold-offs on request
	initial begin
		summary_ch.ready <= 1'b0;
		rx_left = 0;
		rx_phase = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				summary_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_pattern = rx_pattern_t'($urandom_range(0, 3));
					rx_left = $urandom_range(20, 200);
				end
				rx_left--;
				rx_phase++;
				case (rx_pattern)
					RX_ALWAYS:   summary_ch.ready <= 1'b1;
					RX_COIN:     summary_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   summary_ch.ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: summary_ch.ready <= (rx_phase % 5 != 4);
					default:     summary_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		frame_ch.valid <= 1'b0;
		frame_ch.payload <= '0;
		burst_left = 0;
		random_bytes = 0;
		random_frames = 0;
		hold_off_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (random_bytes < RANDOM_BYTES || random_frames < RANDOM_FRAMES_MIN) begin
			if (random_frames == 3 || random_frames == 9)
				hold_off_req = 1'b1;
			make_random_frame();
			random_bytes += frame_q.size();
			random_frames++;
			send_frame();
		end
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (summaries_owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
